[src/ebp_pkg.sv]
// Shared types and constants for the eight-to-seven bit packer.
`default_nettype none

package ebp_pkg;

   localparam int GroupLen = 7;
   localparam int LowWidth = 7;
   localparam int CountWidth = 3;

   localparam logic [LowWidth-1:0] FirstTopBit = 7'h40;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_payload;
   } req_type;

   typedef struct packed {
      logic [LowWidth-1:0] out_byte;
      logic                is_header;
      logic                last_of_run;
   } rsp_type;

   // One finished group as handed from the collector to the emitter.
   typedef struct packed {
      logic [LowWidth-1:0]                header;
      logic [GroupLen-1:0][LowWidth-1:0]  low_bytes;
      logic [CountWidth-1:0]              count;
   } group_type;

endpackage

`default_nettype wire

[src/ebp_collect.sv]
// Group collector: gathers top bits and low bits of incoming bytes.
`default_nettype none

module ebp_collect
   import ebp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_stall,
   input  wire req_type   req_data,
   input  wire logic      emit_free,
   output logic           group_valid,
   output group_type      group_data
);

   logic [CountWidth-1:0]              fill_ff, fill_in;
   logic [LowWidth-1:0]                top_ff, top_in;
   logic [GroupLen-1:0][LowWidth-1:0]  buf_ff;
   logic [CountWidth-1:0]              idx;
   logic [LowWidth-1:0]                top_base;
   logic                               closing;
   logic                               accept;

   always_comb begin
      // A fill count of seven cannot occur; it is handled as a group start.
      idx = (fill_ff == CountWidth'(GroupLen)) ? '0 : fill_ff;
      closing = (idx == CountWidth'(GroupLen - 1)) || req_data.end_of_payload;
      req_stall = closing && !emit_free;
      accept = req_valid && !req_stall;

      top_base = (idx == '0) ? '0 : top_ff;
      top_in = top_base | (req_data.data_byte[7] ? (FirstTopBit >> idx) : '0);

      group_data.header = top_in;
      for (int i = 0; i < GroupLen; i++) begin
         group_data.low_bytes[i] = (idx == CountWidth'(i)) ?
                                   req_data.data_byte[LowWidth-1:0] : buf_ff[i];
      end
      group_data.count = idx + CountWidth'(1);
      group_valid = accept && closing;

      fill_in = closing ? '0 : idx + CountWidth'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         top_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
         top_ff <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff[idx] <= req_data.data_byte[LowWidth-1:0];
      end
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff != CountWidth'(GroupLen))
      else $error("fill count reached the group length");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      group_valid |=> (fill_ff == '0))
      else $error("fill count not cleared after a group was handed off");

   a_handoff_free: assert property (@(posedge clock) disable iff (reset)
      group_valid |-> emit_free)
      else $error("group handed off while the emitter was busy");

endmodule

`default_nettype wire

[src/ebp_emit.sv]
// Group emitter: holds one finished group and sends it out one byte per cycle while rsp_stall is low.
`default_nettype none

module ebp_emit
   import ebp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      group_valid,
   input  wire group_type group_data,
   output logic           emit_free,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_type        rsp_data
);

   logic                  busy_ff;
   logic [CountWidth-1:0] pos_ff;
   group_type             grp_ff;
   logic                  take;
   logic                  last;

   always_comb begin
      last = (pos_ff == grp_ff.count);
      take = busy_ff && !rsp_stall;
      emit_free = !busy_ff || (take && last);

      rsp_valid = busy_ff;
      rsp_data.is_header = (pos_ff == '0);
      rsp_data.last_of_run = last;
      rsp_data.out_byte = (pos_ff == '0) ? grp_ff.header :
                          grp_ff.low_bytes[pos_ff - CountWidth'(1)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff <= '0;
      end else if (group_valid) begin
         busy_ff <= 1'b1;
         pos_ff <= '0;
      end else if (take) begin
         busy_ff <= !last;
         pos_ff <= pos_ff + CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (group_valid) begin
         grp_ff <= group_data;
      end
   end

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff <= grp_ff.count))
      else $error("byte position ran past the end of the group");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (grp_ff.count != '0))
      else $error("busy emitter holds an empty group");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (take && last && !group_valid) |=> !busy_ff)
      else $error("emitter stayed busy after its last byte");

endmodule

`default_nettype wire

[src/eight_to_seven_bit_packer.sv]
// Top level of the eight-to-seven bit packer.
//
// The packer takes payload bytes on the req_ channel, one item per accepted
// handshake, and returns seven-bit bytes on the rsp_ channel. Every run of up
// to seven input bytes becomes a header item carrying their top bits (bit 6
// for the first byte of the group) followed by one item per byte with its low
// seven bits. A group is closed by its seventh byte or by a byte with
// end_of_payload set; last_of_run marks the final item of each group.
// A byte that does not close a group is absorbed into the collector and
// produces no output. A closing byte hands the whole group to the emitter,
// and its header appears on rsp_ in the cycle after acceptance. The emitter
// sends one item per cycle while rsp_stall is low; a group of n bytes gives
// n + 1 items, and input items are taken every cycle while they go out.
// Only a closing byte waits (req_stall high) until the emitter is idle or
// about to drain its last item.
// Reset clears the group fill count, the top bits and the emitter's busy
// flag. When the receiver holds rsp_stall, the current output item stays put
// and new bytes keep filling the next group.
`default_nettype none

module eight_to_seven_bit_packer
   import ebp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // Handoff between the collector and the emitter.
   logic      emit_free;
   logic      group_valid;
   group_type group_data;

   // Collector: accumulates the current group in registers.
   ebp_collect u_collect (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .emit_free   (emit_free),
      .group_valid (group_valid),
      .group_data  (group_data)
   );

   // Emitter: holds one finished group and drives the result channel.
   ebp_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .group_valid (group_valid),
      .group_data  (group_data),
      .emit_free   (emit_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

[tb/tb_eight_to_seven_bit_packer.sv]
// Self-checking testbench for the eight-to-seven bit packer.
`timescale 1ns / 100ps

module tb_eight_to_seven_bit_packer;
   import ebp_pkg::*;

   localparam int ClockPeriod = 8;
   localparam int ResetCycles = 7;
   // Longest run of cycles with no handshake on either side before the run
   // is declared hung. The slowest correct run idles for at most one long
   // sender gap plus one long receiver stall in a row, well under this.
   localparam int HangLimit = 2000;
   // Cycles to keep watching after the last expected item has arrived.
   localparam int DrainCycles = 16;
   localparam int RandomItems = 232;
   localparam int MaxReported = 10;

   // Packing predictor and store of expected output items. Each accepted
   // payload byte updates a private copy of the group state; a byte that
   // closes a group queues the header and the low-bit bytes it releases.
   class packer_scoreboard;
      logic [LowWidth-1:0] header_acc = '0;
      logic [LowWidth-1:0] low_held [GroupLen];
      int                  held_count = 0;
      rsp_type             packed_due [$];
      int                  mismatches = 0;
      int                  items_checked = 0;
      int                  groups_closed = 0;
      int                  early_flushes = 0;

      function new();
         foreach (low_held[i]) low_held[i] = '0;
      endfunction

      function void note_byte(req_type req);
         int      slot;
         rsp_type due;
         slot = (held_count >= GroupLen) ? 0 : held_count;
         // A fresh group starts with an empty header.
         if (slot == 0) header_acc = '0;
         if (req.data_byte[7]) header_acc = header_acc | (FirstTopBit >> slot);
         low_held[slot] = req.data_byte[LowWidth-1:0];
         if (slot + 1 == GroupLen || req.end_of_payload) begin
            due.out_byte    = header_acc;
            due.is_header   = 1'b1;
            due.last_of_run = 1'b0;
            packed_due.push_back(due);
            for (int i = 0; i <= slot; i++) begin
               due.out_byte    = low_held[i];
               due.is_header   = 1'b0;
               due.last_of_run = (i == slot);
               packed_due.push_back(due);
            end
            held_count = 0;
            groups_closed++;
            if (slot + 1 < GroupLen) early_flushes++;
         end else begin
            held_count = slot + 1;
         end
      endfunction

      function void check_item(rsp_type got);
         rsp_type want;
         items_checked++;
         if (packed_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReported)
               $display("%0t: unexpected output item out_byte=%h is_header=%b last=%b",
                        $time, got.out_byte, got.is_header, got.last_of_run);
            return;
         end
         want = packed_due.pop_front();
         if (got.out_byte !== want.out_byte || got.is_header !== want.is_header ||
             got.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= MaxReported)
               $display({"%0t: output item %0d: expected out_byte=%h is_header=%b",
                         " last=%b, got out_byte=%h is_header=%b last=%b"},
                        $time, items_checked, want.out_byte, want.is_header,
                        want.last_of_run, got.out_byte, got.is_header, got.last_of_run);
         end
      endfunction

      function int pending_count();
         return packed_due.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Idling switches for the two sides, changed from phase to phase so that
   // some stretches run back to back and others are full of gaps and stalls.
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   packer_scoreboard sb;
   int bytes_sent = 0;
   int quiet_cycles = 0;

   eight_to_seven_bit_packer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // Mostly no gap or a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random payload byte with the corner values drawn more often.
   function automatic logic [7:0] pick_data();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Presents one payload byte after an optional idle gap and holds it until
   // the block takes it. Inputs only change at the falling edge, and the
   // handshake is judged from the values seen at the rising edge.
   task automatic send_payload_byte(input logic [7:0] data, input bit end_mark);
      int      gap;
      req_type req;
      gap = req_idle_on ? pick_gap() : 0;
      req.data_byte      = data;
      req.end_of_payload = end_mark;
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = req;
      do @(posedge clock); while (req_stall);
      sb.note_byte(req);
      bytes_sent++;
   endtask

   // Sends a list of bytes; only the last one carries the end mark if asked.
   task automatic send_run(input logic [7:0] data [$], input bit end_mark);
      foreach (data[i]) send_payload_byte(data[i], end_mark && (i == data.size() - 1));
   endtask

   // Receiver: stalls start at random and last a short or a long while.
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_idle_on && stall_left == 0 && $urandom_range(0, 3) == 0)
            stall_left = 1 + pick_gap();
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // Every output item taken by the receiver is checked against the oldest
   // expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) sb.check_item(rsp_data);
   end

   // Hang guard: a long stretch without any handshake ends the run.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HangLimit) begin
         $display("%0t: no handshake for %0d cycles, %0d output items still due",
                  $time, HangLimit, sb.pending_count());
         $display("eight_to_seven_bit_packer: mismatch");
         $finish;
      end
   end

   initial begin : main
      int end_odds;
      sb = new();
      repeat (ResetCycles) @(negedge clock);
      reset = 1'b0;

      // Directed part. A lone zero byte and a lone 0xFF byte give the
      // smallest groups with an empty and a set header bit.
      send_run('{8'h00}, 1'b1);
      send_run('{8'hFF}, 1'b1);
      // A full group closed by its seventh byte alone, mixed top bits.
      send_run('{8'h80, 8'h01, 8'hFF, 8'h7F, 8'h00, 8'hAA, 8'h55}, 1'b0);
      // A full group whose seventh byte also carries the end mark: only the
      // group itself comes out, nothing is flushed on top.
      send_run('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1);
      // Partial flushes of three and six bytes; each next byte starts over.
      send_run('{8'h12, 8'h93, 8'h5C}, 1'b1);
      send_run('{8'h81, 8'h02, 8'h83, 8'h04, 8'h85, 8'h86}, 1'b1);

      // Random part in four phases: back to back, sender gaps only,
      // receiver stalls only, and both. The odds of an end mark vary so
      // that short partial groups and long payloads both show up.
      for (int phase = 0; phase < 4; phase++) begin
         req_idle_on = (phase == 1 || phase == 3);
         rsp_idle_on = (phase == 2 || phase == 3);
         case (phase)
            0: end_odds = 3;
            1: end_odds = 6;
            2: end_odds = 12;
            default: end_odds = 4;
         endcase
         for (int n = 0; n < RandomItems / 4; n++)
            send_payload_byte(pick_data(), $urandom_range(0, end_odds - 1) == 0);
      end
      // Close any open group so that every byte is checked.
      send_payload_byte(pick_data(), 1'b1);
      @(negedge clock);
      req_valid = 1'b0;

      while (sb.pending_count() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d payload bytes and checked %0d packed bytes in %0d groups.",
               bytes_sent, sb.items_checked, sb.groups_closed);
      $display("%0d groups were cut short by an end mark; idling varied by phase.",
               sb.early_flushes);
      if (sb.pending_count() > 0)
         $display("%0d expected output items never arrived", sb.pending_count());
      if (sb.mismatches > MaxReported)
         $display("%0d mismatches in total", sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_count() == 0)
         $display("eight_to_seven_bit_packer: match");
      else
         $display("eight_to_seven_bit_packer: mismatch");
      $finish;
   end

endmodule

[files.f]
src/ebp_pkg.sv
src/ebp_collect.sv
src/ebp_emit.sv
src/eight_to_seven_bit_packer.sv
tb/tb_eight_to_seven_bit_packer.sv
